>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/sle_pkg.sv
package sle_pkg;

  localparam int unsigned ListDepth = 1024;
  localparam int unsigned AddrW = $clog2(ListDepth);
  localparam int unsigned CntW = $clog2(ListDepth + 1);
  localparam int unsigned DataW = 32;

  localparam logic [2:0] OpInsert = 3'd0;
  localparam logic [2:0] OpDelete = 3'd1;
  localparam logic [2:0] OpFind = 3'd2;
  localparam logic [2:0] OpCount = 3'd3;
  localparam logic [2:0] OpDedup = 3'd4;
  localparam logic [2:0] OpRemRange = 3'd5;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StBadPos = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

endpackage

>>> sv/sle_ram.sv
module sle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/sequential_list_engine.sv
// Work per request: insert/delete walk the entries moved; find scans up to the
//   first hit; count and remove range scan the whole list; remove repeats scans
//   the kept prefix per entry; rejects and unused opcodes go straight to S_OUT.
// Throughput: one request at a time; in_ready_o is low while a request runs and
//   returns in the cycle after the result is taken. One RAM port pair sets it all.
// Reset: list length clears to zero; store contents are not cleared.
`include "assert_macros.svh"

module sequential_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [10:0] position_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] upper_bound_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [10:0] found_position_o,
  output logic [10:0] range_count_o,
  output logic [10:0] list_length_o
);

  localparam int unsigned AW = sle_pkg::AddrW;
  localparam int unsigned CW = sle_pkg::CntW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,  // issue read
    S_EVAL  = 6'b000100,  // data back, act
    S_INNER = 6'b001000,  // dedup inner read
    S_IEVAL = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] op_q, op_d;
  logic [CW-1:0] pos_q, pos_d, len_q, len_d;
  logic signed [31:0] lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0] j_q, j_d, w_q, w_d, k_q, k_d, cnt_q, cnt_d, fnd_q, fnd_d;
  logic signed [31:0] cur_q, cur_d;
  logic [1:0] st_q, st_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [31:0] wdata, rdata;

  sle_ram #(.Width(sle_pkg::DataW), .Depth(sle_pkg::ListDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic in_rng;
  assign in_rng = (rdata >= lo_q) && (rdata <= hi_q);

  always_comb begin
    state_d = state_q; op_d = op_q; pos_d = pos_q; len_d = len_q;
    lo_d = lo_q; hi_d = hi_q; j_d = j_q; w_d = w_q; k_d = k_q;
    cnt_d = cnt_q; fnd_d = fnd_q; cur_d = cur_q; st_d = st_q;
    we = 1'b0; waddr = j_q[AW-1:0]; wdata = rdata; raddr = j_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = opcode_i; pos_d = position_i[CW-1:0];
          lo_d = value_i; hi_d = upper_bound_i;
          cnt_d = '0; fnd_d = '0; st_d = sle_pkg::StDone;
          w_d = '0; j_d = '0; state_d = S_RD;
          case (opcode_i)
            sle_pkg::OpInsert: begin
              if (len_q == CW'(sle_pkg::ListDepth)) begin
                st_d = sle_pkg::StFull; state_d = S_OUT;
              end else if (position_i == '0 || position_i > 11'(len_q) + 11'd1) begin
                st_d = sle_pkg::StBadPos; state_d = S_OUT;
              end else begin
                j_d = len_q;  // walk down, moving j-1 to j
              end
            end
            sle_pkg::OpDelete: begin
              if (position_i == '0 || position_i > 11'(len_q)) begin
                st_d = sle_pkg::StBadPos; state_d = S_OUT;
              end else begin
                j_d = position_i[CW-1:0];  // move j to j-1
              end
            end
            sle_pkg::OpFind, sle_pkg::OpCount, sle_pkg::OpDedup,
            sle_pkg::OpRemRange: ;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_RD: begin
        case (op_q)
          sle_pkg::OpInsert: begin
            if (j_q == pos_q - CW'(1)) begin
              we = 1'b1; waddr = j_q[AW-1:0]; wdata = lo_q;
              len_d = len_q + CW'(1); state_d = S_OUT;
            end else begin
              raddr = AW'(j_q - CW'(1)); state_d = S_EVAL;
            end
          end
          sle_pkg::OpDelete: begin
            if (j_q >= len_q) begin
              len_d = len_q - CW'(1); state_d = S_OUT;
            end else state_d = S_EVAL;
          end
          default: begin
            if (j_q >= len_q) begin
              if (op_q == sle_pkg::OpDedup || op_q == sle_pkg::OpRemRange) len_d = w_q;
              state_d = S_OUT;
            end else state_d = S_EVAL;
          end
        endcase
      end
      S_EVAL: begin
        state_d = S_RD;
        j_d = j_q + CW'(1);
        case (op_q)
          sle_pkg::OpInsert: begin
            we = 1'b1; waddr = j_q[AW-1:0]; j_d = j_q - CW'(1);
          end
          sle_pkg::OpDelete: begin
            we = 1'b1; waddr = AW'(j_q - CW'(1));
          end
          sle_pkg::OpFind: begin
            if (rdata == lo_q) begin
              fnd_d = j_q + CW'(1); state_d = S_OUT;
            end
          end
          sle_pkg::OpCount: begin
            if (in_rng) cnt_d = cnt_q + CW'(1);
          end
          sle_pkg::OpRemRange: begin
            if (!in_rng) begin
              we = 1'b1; waddr = w_q[AW-1:0]; w_d = w_q + CW'(1);
            end
          end
          default: begin  // dedup: scan kept prefix
            cur_d = rdata; k_d = '0; j_d = j_q; state_d = S_INNER;
            raddr = '0;
          end
        endcase
      end
      S_INNER: begin
        if (k_q >= w_q) begin
          we = 1'b1; waddr = w_q[AW-1:0]; wdata = cur_q;
          w_d = w_q + CW'(1); j_d = j_q + CW'(1); state_d = S_RD;
        end else begin
          raddr = k_q[AW-1:0]; state_d = S_IEVAL;
        end
      end
      S_IEVAL: begin
        if (rdata == cur_q) begin
          j_d = j_q + CW'(1); state_d = S_RD;
        end else begin
          k_d = k_q + CW'(1); state_d = S_INNER;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= '0;
    end else begin
      state_q <= state_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; pos_q <= pos_d; lo_q <= lo_d; hi_q <= hi_d;
    j_q <= j_d; w_q <= w_d; k_q <= k_d; cnt_q <= cnt_d;
    fnd_q <= fnd_d; cur_q <= cur_d; st_q <= st_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o = st_q;
  assign found_position_o = 11'(fnd_q);
  assign range_count_o = 11'(cnt_q);
  assign list_length_o = 11'(len_q);

  `ASSERT_IMPL(a_len_max, clk_i, rst_ni, 1'b1, len_q <= CW'(sle_pkg::ListDepth))
  `ASSERT_IMPL(a_busy_excl, clk_i, rst_ni, 1'b1, !(in_ready_o && out_valid_o))
  `ASSERT_NEXT(a_len_idle, clk_i, rst_ni, state_q == S_IDLE && !in_valid_i, $stable(len_q))
  `ASSERT_IMPL(a_wr_bound, clk_i, rst_ni, we, waddr < AW'(sle_pkg::ListDepth - 1) ||
               waddr == AW'(sle_pkg::ListDepth - 1))

endmodule

>>> verif/testbench.sv
module testbench;

  localparam logic [2:0] OpSpareLo = 3'd6;
  localparam logic [2:0] OpSpareHi = 3'd7;
  localparam int IntMin = 32'sh8000_0000;
  localparam int IntMax = 32'sh7fff_ffff;
  localparam int CycleLimit = 10_000_000;
  localparam int RandItems = 550;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] found;
    logic [10:0] hits;
    logic [10:0] length;
  } answer_t;

  typedef struct {
    logic [2:0]  op;
    logic [10:0] pos;
    int          val;
    int          hi;
    bit          typed;
    answer_t     ans;
  } cmd_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = '0;
  logic [10:0] position_i = '0;
  logic signed [31:0] value_i = '0;
  logic signed [31:0] upper_bound_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [10:0] found_position_o;
  logic [10:0] range_count_o;
  logic [10:0] list_length_o;

  sequential_list_engine dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  int      shadow_list [sle_pkg::ListDepth];
  int      shadow_len = 0;
  answer_t pending_answers[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      calm = 1'b0;

  // Shadow copy of the list; returns the answer the engine should give.
  function automatic answer_t apply_cmd(logic [2:0] op, logic [10:0] pos, int lo, int hi);
    answer_t a;
    int w;
    bit seen;
    a = '0;
    case (op)
      sle_pkg::OpInsert: begin
        if (shadow_len >= sle_pkg::ListDepth) a.status = sle_pkg::StFull;
        else if (pos < 1 || pos > shadow_len + 1) a.status = sle_pkg::StBadPos;
        else begin
          for (int j = shadow_len; j > pos - 1; j--) shadow_list[j] = shadow_list[j-1];
          shadow_list[pos-1] = lo;
          shadow_len++;
        end
      end
      sle_pkg::OpDelete: begin
        if (pos < 1 || pos > shadow_len) a.status = sle_pkg::StBadPos;
        else begin
          for (int j = pos - 1; j + 1 < shadow_len; j++) shadow_list[j] = shadow_list[j+1];
          shadow_len--;
        end
      end
      sle_pkg::OpFind: begin
        for (int j = 0; j < shadow_len; j++)
          if (shadow_list[j] == lo) begin
            a.found = 11'(j + 1);
            break;
          end
      end
      sle_pkg::OpCount: begin
        for (int j = 0; j < shadow_len; j++)
          if (shadow_list[j] >= lo && shadow_list[j] <= hi) a.hits++;
      end
      sle_pkg::OpDedup: begin
        w = 0;
        for (int j = 0; j < shadow_len; j++) begin
          seen = 1'b0;
          for (int k = 0; k < w; k++)
            if (shadow_list[k] == shadow_list[j]) seen = 1'b1;
          if (!seen) begin
            shadow_list[w] = shadow_list[j];
            w++;
          end
        end
        shadow_len = w;
      end
      sle_pkg::OpRemRange: begin
        w = 0;
        for (int j = 0; j < shadow_len; j++)
          if (shadow_list[j] < lo || shadow_list[j] > hi) begin
            shadow_list[w] = shadow_list[j];
            w++;
          end
        shadow_len = w;
      end
      default: ;
    endcase
    a.length = 11'(shadow_len);
    return a;
  endfunction

  task automatic issue(logic [2:0] op, logic [10:0] pos, int lo, int hi,
                       bit typed = 1'b0, answer_t ans = '0);
    answer_t p;
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    opcode_i = op;
    position_i = pos;
    value_i = lo;
    upper_bound_i = hi;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    p = apply_cmd(op, pos, lo, hi);
    pending_answers.push_back(typed ? ans : p);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  always @(negedge clk_i)
    out_ready_i <= calm || ($urandom_range(99) >= 34);

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_o, found_position_o, range_count_o, list_length_o};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  cmd_row_t directed[] = '{
    '{sle_pkg::OpFind, 11'd0, 5, 0, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd0}},
    '{sle_pkg::OpDelete, 11'd1, 0, 0, 1, '{sle_pkg::StBadPos, 11'd0, 11'd0, 11'd0}},
    '{sle_pkg::OpInsert, 11'd0, 3, 0, 1, '{sle_pkg::StBadPos, 11'd0, 11'd0, 11'd0}},
    '{sle_pkg::OpInsert, 11'd2047, -1, 0, 1, '{sle_pkg::StBadPos, 11'd0, 11'd0, 11'd0}},
    '{sle_pkg::OpInsert, 11'd1, IntMin, 0, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd1}},
    '{sle_pkg::OpInsert, 11'd2, IntMax, 0, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd2}},
    '{sle_pkg::OpInsert, 11'd1, 0, 0, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd3}},
    '{sle_pkg::OpFind, 11'd0, IntMax, 0, 1, '{sle_pkg::StDone, 11'd3, 11'd0, 11'd3}},
    '{sle_pkg::OpCount, 11'd0, IntMin, IntMax, 1, '{sle_pkg::StDone, 11'd0, 11'd3, 11'd3}},
    '{sle_pkg::OpCount, 11'd0, 5, -5, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd3}},
    '{OpSpareLo, 11'd5, 7, 9, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd3}},
    '{OpSpareHi, 11'd2047, -1, -1, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd3}},
    '{sle_pkg::OpInsert, 11'd4, 0, 0, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd4}},
    '{sle_pkg::OpInsert, 11'd3, IntMax, 0, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd5}},
    '{sle_pkg::OpDedup, 11'd0, 0, 0, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd3}},
    '{sle_pkg::OpRemRange, 11'd0, 5, -5, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd3}},
    '{sle_pkg::OpDelete, 11'd4, 0, 0, 1, '{sle_pkg::StBadPos, 11'd0, 11'd0, 11'd3}},
    '{sle_pkg::OpDelete, 11'd1024, 0, 0, 1, '{sle_pkg::StBadPos, 11'd0, 11'd0, 11'd3}},
    '{sle_pkg::OpInsert, 11'd1024, 1, 0, 1, '{sle_pkg::StBadPos, 11'd0, 11'd0, 11'd3}},
    '{sle_pkg::OpRemRange, 11'd0, IntMin, -1, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd2}},
    '{sle_pkg::OpDelete, 11'd2, 0, 0, 1, '{sle_pkg::StDone, 11'd0, 11'd0, 11'd1}},
    '{sle_pkg::OpFind, 11'd0, 0, 0, 1, '{sle_pkg::StDone, 11'd1, 11'd0, 11'd1}},
    '{sle_pkg::OpCount, 11'd0, 0, 0, 1, '{sle_pkg::StDone, 11'd0, 11'd1, 11'd1}},
    '{sle_pkg::OpFind, 11'd0, 9, 0, 0, '0}
  };

  // Small pool so finds, duplicates and ranges actually hit.
  function automatic int pick_value();
    if ($urandom_range(99) < 65) return int'($urandom_range(12)) - 6;
    return int'($urandom);
  endfunction

  initial begin
    logic [2:0]  op;
    logic [10:0] pos;
    int lo, hi, roll, tmp;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i])
      issue(directed[i].op, directed[i].pos, directed[i].val, directed[i].hi,
            directed[i].typed, directed[i].ans);

    // Fill to capacity by appending, then hit the full-list case.
    while (shadow_len < sle_pkg::ListDepth)
      issue(sle_pkg::OpInsert, 11'(shadow_len + 1), int'($urandom), 0);
    issue(sle_pkg::OpInsert, 11'd1, 0, 0, 1'b1,
          '{sle_pkg::StFull, 11'd0, 11'd0, 11'd1024});
    issue(sle_pkg::OpCount, 11'd0, IntMin, IntMax, 1'b1,
          '{sle_pkg::StDone, 11'd0, 11'd1024, 11'd1024});
    issue(sle_pkg::OpFind, 11'd0, shadow_list[sle_pkg::ListDepth-1], 0);
    issue(sle_pkg::OpDelete, 11'd1025, 0, 0, 1'b1,
          '{sle_pkg::StBadPos, 11'd0, 11'd0, 11'd1024});
    issue(sle_pkg::OpDelete, 11'd1024, 0, 0);
    issue(sle_pkg::OpRemRange, 11'd0, IntMin, IntMax, 1'b1,
          '{sle_pkg::StDone, 11'd0, 11'd0, 11'd0});

    for (int n = 0; n < RandItems; n++) begin
      calm = (n >= 200 && n < 280);
      roll = $urandom_range(99);
      if (shadow_len > 60 && roll < 35) roll = 40;
      if (roll < 38) op = sle_pkg::OpInsert;
      else if (roll < 58) op = sle_pkg::OpDelete;
      else if (roll < 72) op = sle_pkg::OpFind;
      else if (roll < 84) op = sle_pkg::OpCount;
      else if (roll < 90) op = sle_pkg::OpDedup;
      else if (roll < 96) op = sle_pkg::OpRemRange;
      else op = $urandom_range(1) ? OpSpareLo : OpSpareHi;
      if ($urandom_range(99) < 15) pos = 11'($urandom_range(2047));
      else if (op == sle_pkg::OpInsert) pos = 11'($urandom_range(shadow_len + 1, 1));
      else pos = 11'($urandom_range(shadow_len > 0 ? shadow_len : 1, 1));
      lo = pick_value();
      hi = ($urandom_range(9) == 0) ? int'($urandom) : lo + int'($urandom_range(4));
      if (op == sle_pkg::OpRemRange && $urandom_range(3) != 0 && lo <= hi) begin
        tmp = lo;
        hi = tmp;  // narrow ranges keep the list populated
      end
      issue(op, pos, lo, hi);
    end
    calm = 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
